// ----- design/art_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// art_pkg
// Shared types and constants for the address region table.
// ----------------------------------------------------------------------------
package art_pkg;

    localparam int CAPACITY  = 4096;
    localparam int ADDR_BITS = 48;
    localparam int END_BITS  = ADDR_BITS + 1;
    localparam int IDX_BITS  = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_UNREGISTER = 2'd1,
        OP_QUERY      = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start_addr;
        logic [END_BITS-1:0]  end_addr;
    } t_entry;

endpackage : art_pkg
`default_nettype wire

// ----- design/address_region_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// address_region_table
// Bounded unordered table of address regions (start, exclusive end) with
// register, unregister-by-start and ownership query operations.
//
// Command channel: an operation is taken at a rising edge where start is
// high and busy is low. Each operation gives exactly one result, shown on
// o_status, o_owned and o_live_count for one cycle while o_valid is high.
// The receiver cannot stall; every result is taken in the cycle it shows.
// Register, unused opcodes, a query of address zero and any operation on an
// empty table answer in the cycle after the transfer, and busy stays low.
// Unregister and query scan the live entries through the region memory,
// one read per cycle through its registered read port: a scan answers once
// an entry matches or, on a miss, once every live entry has been compared,
// and an unregister that moves the last entry into the hole first reads
// that entry and writes it into the hole in ST_MOVE. The scan length is
// set by the single read port of the region memory.
// Reset clears the live count and control state; the memory itself is not
// cleared since only live entries are ever read.
// ----------------------------------------------------------------------------
module address_region_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_opcode,
    input  logic [art_pkg::ADDR_BITS-1:0] i_address,
    input  logic [art_pkg::ADDR_BITS-1:0] i_length,
    output logic                          o_valid,
    output logic                          o_status,
    output logic                          o_owned,
    output logic [art_pkg::CNT_BITS-1:0]  o_live_count
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_MOVE = 3'b100
    } t_state;

    art_pkg::t_entry r_mem [art_pkg::CAPACITY];
    art_pkg::t_entry r_rd_data;

    t_state                          r_state,   n_state;
    logic [art_pkg::CNT_BITS-1:0]    r_count,   n_count;
    logic [art_pkg::CNT_BITS-1:0]    r_rd_idx,  n_rd_idx;
    logic                            r_rd_vld,  n_rd_vld;
    logic [art_pkg::IDX_BITS-1:0]    r_cmp_idx, n_cmp_idx;
    logic [art_pkg::IDX_BITS-1:0]    r_hit_idx, n_hit_idx;
    art_pkg::t_op                    r_op,      n_op;
    logic [art_pkg::ADDR_BITS-1:0]   r_addr,    n_addr;
    logic                            r_out_vld, n_out_vld;
    logic                            r_status,  n_status;
    logic                            r_owned,   n_owned;

    logic                            rd_en;
    logic [art_pkg::IDX_BITS-1:0]    rd_addr;
    logic                            wr_en;
    logic [art_pkg::IDX_BITS-1:0]    wr_addr;
    art_pkg::t_entry                 wr_data;

    logic                            accept;
    logic                            full;
    logic                            issue;
    logic                            hit;
    art_pkg::t_op                    in_op;
    logic [art_pkg::CNT_BITS-1:0]    count_m1;
    logic [art_pkg::IDX_BITS-1:0]    last_idx;
    logic [art_pkg::END_BITS-1:0]    new_end;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign in_op    = art_pkg::t_op'(i_opcode);
    assign full     = (r_count == art_pkg::CNT_BITS'(art_pkg::CAPACITY));
    assign issue    = (r_rd_idx < r_count);
    assign count_m1 = r_count - art_pkg::CNT_BITS'(1);
    assign last_idx = count_m1[art_pkg::IDX_BITS-1:0];
    assign new_end  = {1'b0, i_address} + {1'b0, i_length};

    art_match u_match (
        .i_op    (r_op),
        .i_entry (r_rd_data),
        .i_probe (r_addr),
        .o_hit   (hit)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rd_idx  = r_rd_idx;
        n_rd_vld  = 1'b0;
        n_cmp_idx = r_cmp_idx;
        n_hit_idx = r_hit_idx;
        n_op      = r_op;
        n_addr    = r_addr;
        n_out_vld = 1'b0;
        n_status  = 1'b0;
        n_owned   = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op   = in_op;
                    n_addr = i_address;
                    unique case (in_op) inside
                        art_pkg::OP_REGISTER: begin
                            n_out_vld = 1'b1;
                            if (full) begin
                                n_status = 1'b1;
                            end else begin
                                wr_en              = 1'b1;
                                wr_addr            = r_count[art_pkg::IDX_BITS-1:0];
                                wr_data.start_addr = i_address;
                                wr_data.end_addr   = new_end;
                                n_count            = r_count + art_pkg::CNT_BITS'(1);
                            end
                        end
                        art_pkg::OP_UNREGISTER, art_pkg::OP_QUERY: begin
                            if ((r_count == '0) ||
                                ((in_op == art_pkg::OP_QUERY) && (i_address == '0))) begin
                                n_out_vld = 1'b1;
                            end else begin
                                rd_en     = 1'b1;
                                rd_addr   = '0;
                                n_rd_idx  = art_pkg::CNT_BITS'(1);
                                n_rd_vld  = 1'b1;
                                n_cmp_idx = '0;
                                n_state   = ST_SCAN;
                            end
                        end
                        default: begin
                            n_out_vld = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    rd_en     = 1'b1;
                    rd_addr   = r_rd_idx[art_pkg::IDX_BITS-1:0];
                    n_rd_idx  = r_rd_idx + art_pkg::CNT_BITS'(1);
                    n_rd_vld  = 1'b1;
                    n_cmp_idx = r_rd_idx[art_pkg::IDX_BITS-1:0];
                end
                if (r_rd_vld && hit) begin
                    n_rd_vld = 1'b0;
                    if (r_op == art_pkg::OP_QUERY) begin
                        n_out_vld = 1'b1;
                        n_owned   = 1'b1;
                        n_state   = ST_IDLE;
                    end else if (r_cmp_idx == last_idx) begin
                        n_count   = count_m1;
                        n_out_vld = 1'b1;
                        n_state   = ST_IDLE;
                    end else begin
                        rd_en     = 1'b1;
                        rd_addr   = last_idx;
                        n_hit_idx = r_cmp_idx;
                        n_state   = ST_MOVE;
                    end
                end else if (!r_rd_vld) begin
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            ST_MOVE: begin
                wr_en     = 1'b1;
                wr_addr   = r_hit_idx;
                wr_data   = r_rd_data;
                n_count   = count_m1;
                n_out_vld = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // region memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_hit_idx <= n_hit_idx;
        r_op      <= n_op;
        r_addr    <= n_addr;
        r_status  <= n_status;
        r_owned   <= n_owned;
    end

    assign o_valid      = r_out_vld;
    assign o_status     = r_status;
    assign o_owned      = r_owned;
    assign o_live_count = r_count;

    // live count stays within the table
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= art_pkg::CNT_BITS'(art_pkg::CAPACITY))
        else $error("live count above capacity");

    // a register into a table with room answers next cycle with one more entry
    a_register_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (in_op == art_pkg::OP_REGISTER) && !full) |=>
        (o_valid && !o_status && (r_count == $past(r_count) + art_pkg::CNT_BITS'(1))))
        else $error("register transfer did not append");

    // ownership is only ever reported for a query
    a_owned_query : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_owned) |-> (r_op == art_pkg::OP_QUERY))
        else $error("owned flag on a non-query result");

    // the swap move never targets the last live entry
    a_move_target : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOVE) |-> (r_hit_idx != last_idx))
        else $error("swap move onto the last entry");

endmodule : address_region_table
`default_nettype wire

// ----- design/art_match.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// art_match
// Compares one stored region against the probe address: start equality for
// unregister, containment for the ownership query.
// ----------------------------------------------------------------------------
module art_match (
    input  art_pkg::t_op                     i_op,
    input  art_pkg::t_entry                  i_entry,
    input  logic [art_pkg::ADDR_BITS-1:0]    i_probe,
    output logic                             o_hit
);

    logic [art_pkg::END_BITS-1:0] probe_ext;
    logic                         start_eq;
    logic                         contains;

    assign probe_ext = {1'b0, i_probe};
    assign start_eq  = (i_entry.start_addr == i_probe);
    assign contains  = (i_probe >= i_entry.start_addr) && (probe_ext < i_entry.end_addr);

    always_comb begin
        case (i_op)
            art_pkg::OP_QUERY:      o_hit = contains;
            art_pkg::OP_UNREGISTER: o_hit = start_eq;
            default:                o_hit = 1'b0;
        endcase
    end

endmodule : art_match
`default_nettype wire
